// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL files.
// Both macros expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define BFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bfq_pkg.sv =====
package bfq_pkg;

    // Kind of an input item.
    typedef logic [1:0] op_t;
    // Status code of a result item.
    typedef logic [1:0] status_t;

    localparam op_t OP_ADD_EDGE = 2'd0;
    localparam op_t OP_RUN      = 2'd1;
    localparam op_t OP_QUERY    = 2'd2;
    localparam op_t OP_CLEAR    = 2'd3;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_FULL      = 2'd1;
    localparam status_t STAT_NEG_CYCLE = 2'd2;
    localparam status_t STAT_RANGE     = 2'd3;

endpackage

// ===== hdl/bfq_ram.sv =====
module bfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/queue_bellman_ford_shortest_path.sv =====
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: opcode; tdata: edge and vertex fields
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: distance and predecessor
// cfg_*     in         cfg_wen            num_vertices
//
// Add and query items pass through ST_ADD or ST_QRY and then ST_RESP, clear and
// rejected items through ST_RESP alone, before the result register is loaded; one
// result register lets the next item in while a result waits.
// A run first sweeps the vertex memory (ST_CLR), then dequeues each vertex through
// ST_POP, ST_POPW and ST_VWR, reads each outgoing edge in ST_ERD and ST_EDAT, adds
// ST_WDAT for an edge whose target is in range, and ends on an empty-queue check in
// ST_POP, all through the single read port of the vertex memory.
// After reset the same sweep runs once before the first item.
// A run holds s_tready low until its result is produced.
module queue_bellman_ford_shortest_path #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // tdata: edge_from[7:0], edge_to[15:8], edge_weight[31:16],
    //        start_vertex[39:32], query_vertex[47:40]
    input  logic [47:0]      s_tdata,
    // tuser: opcode[1:0]
    input  bfq_pkg::op_t     s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // tdata: distance[31:0], reachable[32], predecessor[40:33],
    //        has_predecessor[41], zero[47:42]
    output logic [47:0]      m_tdata,
    // tuser: status[1:0]
    output bfq_pkg::status_t m_tuser,
    input  logic             cfg_wen,
    input  logic [8:0]       cfg_wdata
);

    import bfq_pkg::*;

    `include "assert_macros.svh"

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int NVW  = $clog2(MAX_VERTICES + 1);
    localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int WB   = WEIGHT_BITS;
    localparam int DW0  = WEIGHT_BITS + 2 * VW + 2;
    localparam int DW   = (DW0 < 33) ? 33 : DW0;
    localparam int WMAX = 2 ** (WEIGHT_BITS - 1) - 1;
    localparam int WMIN = -(2 ** (WEIGHT_BITS - 1));

    localparam logic signed [DW-1:0] D_HI = DW'(64'sd2147483647);
    localparam logic signed [DW-1:0] D_LO = DW'(-64'sd2147483648);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_ADD  = 4'd2;
    localparam logic [3:0] ST_SEED = 4'd3;
    localparam logic [3:0] ST_POP  = 4'd4;
    localparam logic [3:0] ST_POPW = 4'd5;
    localparam logic [3:0] ST_VWR  = 4'd6;
    localparam logic [3:0] ST_ERD  = 4'd7;
    localparam logic [3:0] ST_EDAT = 4'd8;
    localparam logic [3:0] ST_WDAT = 4'd9;
    localparam logic [3:0] ST_QRY  = 4'd10;
    localparam logic [3:0] ST_RESP = 4'd11;

    typedef struct packed {
        logic signed [DW-1:0] path_len;
        logic                 fin;
        logic [VW-1:0]        pred;
        logic                 pv;
        logic                 queued;
        logic [NVW-1:0]       cnt;
    } vrec_t;

    typedef struct packed {
        logic [EW-1:0] head;
        logic [EW-1:0] tail;
    } adj_t;

    typedef struct packed {
        logic [VW-1:0]        target;
        logic signed [WB-1:0] cost;
    } einfo_t;

    // Control and datapath registers.
    logic [3:0]           state_reg, state_next;
    logic [8:0]           cfg_reg;
    logic [VW-1:0]        clr_idx_reg, clr_idx_next;
    logic                 clr_run_reg, clr_run_next;
    logic [7:0]           from_reg, from_next;
    logic [7:0]           to_reg, to_next;
    logic signed [WB-1:0] wt_reg, wt_next;
    logic [7:0]           start_reg, start_next;
    logic [ECW-1:0]       edge_cnt_reg, edge_cnt_next;
    logic [MAX_VERTICES-1:0] adj_valid_reg, adj_valid_next;
    logic [VW-1:0]        q_head_reg, q_head_next;
    logic [VW-1:0]        q_tail_reg, q_tail_next;
    logic [NVW-1:0]       q_len_reg, q_len_next;
    logic [VW-1:0]        v_reg, v_next;
    logic signed [DW-1:0] dist_v_reg, dist_v_next;
    logic [EW-1:0]        e_reg, e_next;
    logic [EW-1:0]        e_last_reg, e_last_next;
    logic [EW-1:0]        nxt_reg, nxt_next;
    logic [VW-1:0]        w_reg, w_next;
    logic signed [DW-1:0] cand_reg, cand_next;
    status_t              res_status_reg, res_status_next;
    logic [31:0]          res_dist_reg, res_dist_next;
    logic                 res_reach_reg, res_reach_next;
    logic [7:0]           res_pred_reg, res_pred_next;
    logic                 res_hp_reg, res_hp_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [47:0]          m_tdata_reg, m_tdata_next;
    status_t              m_tuser_reg, m_tuser_next;

    // Memory ports.
    logic          v_we;
    logic [VW-1:0] v_waddr, v_raddr;
    vrec_t         v_wdata, v_rdata;
    logic          a_we;
    logic [VW-1:0] a_waddr, a_raddr;
    adj_t          a_wdata, a_rdata;
    logic          i_we;
    logic [EW-1:0] i_waddr, i_raddr;
    einfo_t        i_wdata, i_rdata;
    logic          n_we;
    logic [EW-1:0] n_waddr, n_raddr, n_wdata, n_rdata;
    logic          q_we;
    logic [VW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    // Decoded input and helpers.
    logic [NVW-1:0]       nv;
    op_t                  in_op;
    logic [7:0]           in_from, in_to, in_start, in_query;
    logic signed [31:0]   in_w32;
    logic signed [WB-1:0] in_wt;
    logic                 relax;
    logic [NVW-1:0]       cnt1;
    vrec_t                upd;
    logic signed [DW-1:0] cost_ext;

    bfq_ram #(.WIDTH($bits(vrec_t)), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    bfq_ram #(.WIDTH($bits(adj_t)), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    bfq_ram #(.WIDTH($bits(einfo_t)), .DEPTH(MAX_EDGES)) u_einfo_ram (
        .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .raddr(i_raddr), .rdata(i_rdata)
    );

    bfq_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_enext_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    bfq_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // Effective vertex count: zero means one, large values clamp to the store size.
    always_comb
    begin
        if (cfg_reg == 9'd0)
        begin
            nv = NVW'(1);
        end
        else if (16'(cfg_reg) > 16'(MAX_VERTICES))
        begin
            nv = NVW'(MAX_VERTICES);
        end
        else
        begin
            nv = NVW'(cfg_reg);
        end
    end

    // Input fields and weight saturation.
    always_comb
    begin
        in_op    = s_tuser;
        in_from  = s_tdata[7:0];
        in_to    = s_tdata[15:8];
        in_start = s_tdata[39:32];
        in_query = s_tdata[47:40];
        in_w32   = 32'(signed'(s_tdata[31:16]));
        if (in_w32 > WMAX)
        begin
            in_wt = WB'(WMAX);
        end
        else if (in_w32 < WMIN)
        begin
            in_wt = WB'(WMIN);
        end
        else
        begin
            in_wt = WB'(in_w32);
        end
    end

    // Relaxation test on the target vertex entry.
    always_comb
    begin
        cost_ext      = {{(DW - WB){i_rdata.cost[WB-1]}}, i_rdata.cost};
        relax         = !v_rdata.fin || ($signed(v_rdata.path_len) > cand_reg);
        cnt1          = v_rdata.cnt + NVW'(1);
        upd           = v_rdata;
        upd.path_len  = cand_reg;
        upd.fin       = 1'b1;
        upd.pred      = v_reg;
        upd.pv        = 1'b1;
    end

    // Main sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        clr_run_next    = clr_run_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        wt_next         = wt_reg;
        start_next      = start_reg;
        edge_cnt_next   = edge_cnt_reg;
        adj_valid_next  = adj_valid_reg;
        q_head_next     = q_head_reg;
        q_tail_next     = q_tail_reg;
        q_len_next      = q_len_reg;
        v_next          = v_reg;
        dist_v_next     = dist_v_reg;
        e_next          = e_reg;
        e_last_next     = e_last_reg;
        nxt_next        = nxt_reg;
        w_next          = w_reg;
        cand_next       = cand_reg;
        res_status_next = res_status_reg;
        res_dist_next   = res_dist_reg;
        res_reach_next  = res_reach_reg;
        res_pred_next   = res_pred_reg;
        res_hp_next     = res_hp_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        v_we    = 1'b0;
        v_waddr = v_reg;
        v_wdata = v_rdata;
        v_raddr = v_reg;
        a_we    = 1'b0;
        a_waddr = VW'(from_reg);
        a_wdata = a_rdata;
        a_raddr = VW'(in_from);
        i_we    = 1'b0;
        i_waddr = EW'(edge_cnt_reg);
        i_wdata = '{target: VW'(to_reg), cost: wt_reg};
        i_raddr = e_reg;
        n_we    = 1'b0;
        n_waddr = a_rdata.tail;
        n_wdata = EW'(edge_cnt_reg);
        n_raddr = e_reg;
        q_we    = 1'b0;
        q_waddr = q_tail_reg;
        q_wdata = w_reg;
        q_raddr = q_head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    from_next       = in_from;
                    to_next         = in_to;
                    wt_next         = in_wt;
                    start_next      = in_start;
                    res_status_next = STAT_OK;
                    res_dist_next   = '0;
                    res_reach_next  = 1'b0;
                    res_pred_next   = '0;
                    res_hp_next     = 1'b0;
                    state_next      = ST_RESP;
                    case (in_op)
                        OP_ADD_EDGE:
                        begin
                            if (16'(in_from) >= 16'(nv) || 16'(in_to) >= 16'(nv))
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else if (edge_cnt_reg == ECW'(MAX_EDGES))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = ST_ADD;
                            end
                        end
                        OP_RUN:
                        begin
                            if (16'(in_start) >= 16'(nv))
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                clr_idx_next = '0;
                                clr_run_next = 1'b1;
                                state_next   = ST_CLR;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (16'(in_query) >= 16'(nv))
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                v_raddr    = VW'(in_query);
                                state_next = ST_QRY;
                            end
                        end
                        default:
                        begin
                            adj_valid_next = '0;
                            edge_cnt_next  = '0;
                        end
                    endcase
                end
            end

            // Append the edge to the end of its source's list.
            ST_ADD:
            begin
                i_we = 1'b1;
                if (adj_valid_reg[VW'(from_reg)])
                begin
                    n_we         = 1'b1;
                    a_wdata.head = a_rdata.head;
                end
                else
                begin
                    a_wdata.head = EW'(edge_cnt_reg);
                end
                a_wdata.tail                  = EW'(edge_cnt_reg);
                a_we                          = 1'b1;
                adj_valid_next[VW'(from_reg)] = 1'b1;
                edge_cnt_next                 = edge_cnt_reg + ECW'(1);
                state_next                    = ST_RESP;
            end

            // Sweep every vertex entry back to unreached.
            ST_CLR:
            begin
                v_we         = 1'b1;
                v_waddr      = clr_idx_reg;
                v_wdata      = '0;
                clr_idx_next = clr_idx_reg + VW'(1);
                if (clr_idx_reg == VW'(MAX_VERTICES - 1))
                begin
                    clr_idx_next = '0;
                    state_next   = clr_run_reg ? ST_SEED : ST_IDLE;
                end
            end

            // Source at distance zero, alone in the queue.
            ST_SEED:
            begin
                v_we        = 1'b1;
                v_waddr     = VW'(start_reg);
                v_wdata     = '0;
                v_wdata.fin = 1'b1;
                v_wdata.queued = 1'b1;
                q_we        = 1'b1;
                q_waddr     = '0;
                q_wdata     = VW'(start_reg);
                q_head_next = '0;
                q_tail_next = (MAX_VERTICES == 1) ? '0 : VW'(1);
                q_len_next  = NVW'(1);
                state_next  = ST_POP;
            end

            ST_POP:
            begin
                if (q_len_reg == '0)
                begin
                    res_status_next = STAT_OK;
                    state_next      = ST_RESP;
                end
                else
                begin
                    q_raddr     = q_head_reg;
                    q_head_next = (q_head_reg == VW'(MAX_VERTICES - 1)) ? '0
                                  : q_head_reg + VW'(1);
                    q_len_next  = q_len_reg - NVW'(1);
                    state_next  = ST_POPW;
                end
            end

            ST_POPW:
            begin
                v_next     = q_rdata;
                v_raddr    = q_rdata;
                a_raddr    = q_rdata;
                state_next = ST_VWR;
            end

            // Take the vertex off the queue and start its edge list.
            ST_VWR:
            begin
                dist_v_next    = v_rdata.path_len;
                v_we           = 1'b1;
                v_waddr        = v_reg;
                v_wdata        = v_rdata;
                v_wdata.queued = 1'b0;
                if (adj_valid_reg[v_reg])
                begin
                    e_next      = a_rdata.head;
                    e_last_next = a_rdata.tail;
                    state_next  = ST_ERD;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end

            ST_ERD:
            begin
                i_raddr    = e_reg;
                n_raddr    = e_reg;
                state_next = ST_EDAT;
            end

            ST_EDAT:
            begin
                w_next    = i_rdata.target;
                cand_next = dist_v_reg + cost_ext;
                nxt_next  = n_rdata;
                v_raddr   = i_rdata.target;
                if (16'(i_rdata.target) >= 16'(nv))
                begin
                    e_next     = n_rdata;
                    state_next = (e_reg == e_last_reg) ? ST_POP : ST_ERD;
                end
                else
                begin
                    state_next = ST_WDAT;
                end
            end

            // Strict relaxation of one edge.
            ST_WDAT:
            begin
                e_next     = nxt_reg;
                state_next = (e_reg == e_last_reg) ? ST_POP : ST_ERD;
                if (relax)
                begin
                    v_we    = 1'b1;
                    v_waddr = w_reg;
                    v_wdata = upd;
                    if (w_reg == v_reg)
                    begin
                        dist_v_next = cand_reg;
                    end
                    if (!v_rdata.queued)
                    begin
                        v_wdata.cnt = cnt1;
                        if (cnt1 >= nv)
                        begin
                            res_status_next = STAT_NEG_CYCLE;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            v_wdata.queued = 1'b1;
                            q_we           = 1'b1;
                            q_waddr        = q_tail_reg;
                            q_wdata        = w_reg;
                            q_tail_next    = (q_tail_reg == VW'(MAX_VERTICES - 1)) ? '0
                                             : q_tail_reg + VW'(1);
                            q_len_next     = q_len_reg + NVW'(1);
                        end
                    end
                end
            end

            // Read out one vertex, distance clamped to 32 bits.
            ST_QRY:
            begin
                if (v_rdata.fin)
                begin
                    res_reach_next = 1'b1;
                    if ($signed(v_rdata.path_len) > D_HI)
                    begin
                        res_dist_next = 32'h7fff_ffff;
                    end
                    else if ($signed(v_rdata.path_len) < D_LO)
                    begin
                        res_dist_next = 32'h8000_0000;
                    end
                    else
                    begin
                        res_dist_next = v_rdata.path_len[31:0];
                    end
                end
                if (v_rdata.pv)
                begin
                    res_hp_next   = 1'b1;
                    res_pred_next = 8'(v_rdata.pred);
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {6'd0, res_hp_reg, res_pred_reg, res_reach_reg,
                                     res_dist_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_idx_reg   <= '0;
            clr_run_reg   <= 1'b0;
            cfg_reg       <= 9'd256;
            edge_cnt_reg  <= '0;
            adj_valid_reg <= '0;
            q_head_reg    <= '0;
            q_tail_reg    <= '0;
            q_len_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clr_run_reg   <= clr_run_next;
            edge_cnt_reg  <= edge_cnt_next;
            adj_valid_reg <= adj_valid_next;
            q_head_reg    <= q_head_next;
            q_tail_reg    <= q_tail_next;
            q_len_reg     <= q_len_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wen)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        from_reg       <= from_next;
        to_reg         <= to_next;
        wt_reg         <= wt_next;
        start_reg      <= start_next;
        v_reg          <= v_next;
        dist_v_reg     <= dist_v_next;
        e_reg          <= e_next;
        e_last_reg     <= e_last_next;
        nxt_reg        <= nxt_next;
        w_reg          <= w_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_dist_reg   <= res_dist_next;
        res_reach_reg  <= res_reach_next;
        res_pred_reg   <= res_pred_next;
        res_hp_reg     <= res_hp_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The marks keep the queue from holding more than one copy of any vertex.
    `BFQ_ASSERT(a_queue_bound, q_len_reg <= NVW'(MAX_VERTICES), "work queue overflow")
    `BFQ_ASSERT(a_edge_bound, edge_cnt_reg <= ECW'(MAX_EDGES), "edge count overflow")
    `BFQ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != ST_IDLE,
        "accepted item did not start work")
    `BFQ_ASSERT_NEXT(a_resp_load, (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready),
        m_tvalid_reg && (state_reg == ST_IDLE), "result not delivered to output")

endmodule
